>>> rtl/hrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_pkg: shared types and constants of the hex record loader
// Character codes, halt codes, the character class passed from front to back
// and the result record.
// ----------------------------------------------------------------------------
package hrl_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int CMP_BITS    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   typedef enum logic [2:0] {
      HALT_NONE      = 3'd0,
      HALT_BAD_START = 3'd1,
      HALT_BAD_SUM   = 3'd2,
      HALT_LIMIT     = 3'd3,
      HALT_SHORT     = 3'd4
   } halt_type;

   typedef struct packed {
      logic       is_nl;
      logic       is_colon;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  data_byte;
      logic [15:0] store_index;
      logic [15:0] load_address;
      logic        unknown_type;
      logic        halted;
      logic [2:0]  halt_reason;
      logic [15:0] bytes_stored;
   } rsp_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d = c - CHAR_ZERO;
      end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
         d = c - CHAR_SEVEN;
      end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
         d = c - CHAR_W;
      end
      return d[3:0];
   endfunction

endpackage

>>> rtl/hex_record_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader: hex record parser, one character per request
// Front classifies characters, a short queue decouples it from the parser,
// and the parser registers one result per character.
//
//   channel   ports          direction   item
//   request   req_*          in          one character code
//   response  rsp_*          out         one result per character
//   config    psel..pready   in/out      byte_limit at address 0
//
// One character per cycle while rsp_ready stays high; an accepted character
// passes the front register, the queue and the result register before
// rsp_valid rises with its result.
// The parser state update pairs two nibbles into a byte and does an 8-bit sum add.
// Reset is synchronous and active high; byte_limit resets to 65535.
// No clearing pass: the block accepts requests in the cycle after reset.
// A stalled response is absorbed by the result register, queue and front.
// ----------------------------------------------------------------------------
module hex_record_loader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_store_index,
   output logic [15:0] rsp_load_address,
   output logic        rsp_unknown_type,
   output logic        rsp_halted,
   output logic [2:0]  rsp_halt_reason,
   output logic [15:0] rsp_bytes_stored,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_BYTE_LIMIT = 1'b0;

   logic [15:0]             byte_limit_ff;
   logic [15:0]             byte_limit_in;
   logic                    f_valid, f_ready;
   hrl_pkg::char_class_type f_item;
   logic                    q_valid, q_ready;
   hrl_pkg::char_class_type q_item;
   hrl_pkg::rsp_type        rsp;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_BYTE_LIMIT) ? {16'h0000, byte_limit_ff} : 32'h0;

   always_comb begin
      byte_limit_in = byte_limit_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_BYTE_LIMIT) begin
         byte_limit_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= 16'hFFFF;
      end else begin
         byte_limit_ff <= byte_limit_in;
      end
   end

   hrl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_item      (f_item)
   );

   hrl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   hrl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .byte_limit (byte_limit_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_byte_valid   = rsp.byte_valid;
   assign rsp_data_byte    = rsp.data_byte;
   assign rsp_store_index  = rsp.store_index;
   assign rsp_load_address = rsp.load_address;
   assign rsp_unknown_type = rsp.unknown_type;
   assign rsp_halted       = rsp.halted;
   assign rsp_halt_reason  = rsp.halt_reason;
   assign rsp_bytes_stored = rsp.bytes_stored;

endmodule

>>> rtl/hrl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_front: request intake and character classification
// Registers each accepted character as newline / colon / hex nibble.
// ----------------------------------------------------------------------------
module hrl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_code,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hrl_pkg::char_class_type out_item
);

   logic                    valid_ff;
   logic                    valid_in;
   hrl_pkg::char_class_type item_ff;
   hrl_pkg::char_class_type item_in;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in.is_nl    = (req_char_code == hrl_pkg::CHAR_NL);
      item_in.is_colon = (req_char_code == hrl_pkg::CHAR_COLON);
      item_in.nibble   = hrl_pkg::nibble_of(req_char_code);
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> rtl/hrl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_queue: short queue between front and back
// Holds classified characters so that either side can stall on its own.
// ----------------------------------------------------------------------------
module hrl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  hrl_pkg::char_class_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hrl_pkg::char_class_type out_item
);

   hrl_pkg::char_class_type      mem_ff [hrl_pkg::QUEUE_DEPTH];
   logic [hrl_pkg::PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hrl_pkg::PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hrl_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                          push, pop;

   assign in_ready  = (count_ff != hrl_pkg::QCNT_BITS'(hrl_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == hrl_pkg::PTR_BITS'(hrl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == hrl_pkg::PTR_BITS'(hrl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> rtl/hrl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_back: record parser and result register
// Walks the record fields, checks the sum and the byte limit, and registers
// one result per character.
// ----------------------------------------------------------------------------
module hrl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  hrl_pkg::char_class_type in_item,
   input  logic [15:0]             byte_limit,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hrl_pkg::rsp_type        rsp
);

   typedef enum logic [2:0] {
      PH_START,
      PH_COUNT,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_CHECK,
      PH_EOL,
      PH_SKIP
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [3:0]                      high_ff, high_in;
   logic                            odd_ff, odd_in;
   logic [7:0]                      count_ff, count_in;
   logic [7:0]                      field_ff, field_in;
   logic [7:0]                      sum_ff, sum_in;
   logic                            type_data_ff, type_data_in;
   logic [15:0]                     addr_ff, addr_in;
   logic [hrl_pkg::COUNT_BITS-1:0]  stored_ff, stored_in;
   hrl_pkg::halt_type               halt_ff, halt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   hrl_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            pop;
   logic                            limit_ok;
   logic [7:0]                      byte_val;
   logic [7:0]                      field_next;

   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign pop       = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign byte_val   = {high_ff, in_item.nibble};
   assign field_next = field_ff + 8'd1;
   assign limit_ok   = (hrl_pkg::CMP_BITS'(stored_ff) < hrl_pkg::CMP_BITS'(byte_limit))
                       && (stored_ff != '1);

   always_comb begin
      phase_in     = phase_ff;
      high_in      = high_ff;
      odd_in       = odd_ff;
      count_in     = count_ff;
      field_in     = field_ff;
      sum_in       = sum_ff;
      type_data_in = type_data_ff;
      addr_in      = addr_ff;
      stored_in    = stored_ff;
      halt_in      = halt_ff;
      rsp_in       = '0;

      if (pop && halt_ff == hrl_pkg::HALT_NONE) begin
         if (byte_limit == '0) begin
            halt_in = hrl_pkg::HALT_LIMIT;
         end else begin
            case (phase_ff)
               PH_EOL, PH_SKIP: begin
                  if (in_item.is_nl) phase_in = PH_START;
               end
               PH_START: begin
                  if (in_item.is_colon) begin
                     phase_in = PH_COUNT;
                     odd_in   = 1'b0;
                     sum_in   = '0;
                     field_in = '0;
                  end else begin
                     halt_in = hrl_pkg::HALT_BAD_START;
                  end
               end
               PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK: begin
                  if (in_item.is_nl) begin
                     halt_in = hrl_pkg::HALT_SHORT;
                  end else if (!odd_ff) begin
                     high_in = in_item.nibble;
                     odd_in  = 1'b1;
                  end else begin
                     odd_in = 1'b0;
                     sum_in = sum_ff + byte_val;
                     case (phase_ff)
                        PH_COUNT: begin
                           count_in = byte_val;
                           sum_in   = byte_val;
                           field_in = '0;
                           phase_in = PH_ADDR;
                        end
                        PH_ADDR: begin
                           if (field_ff == '0) begin
                              addr_in  = {byte_val, 8'h00};
                              field_in = 8'd1;
                           end else begin
                              addr_in  = {addr_ff[15:8], byte_val};
                              phase_in = PH_TYPE;
                           end
                        end
                        PH_TYPE: begin
                           type_data_in = (byte_val == 8'd0);
                           field_in     = '0;
                           if (byte_val > 8'd1) begin
                              rsp_in.unknown_type = 1'b1;
                              phase_in            = PH_SKIP;
                           end else begin
                              phase_in = (count_ff != '0) ? PH_DATA : PH_CHECK;
                           end
                        end
                        PH_DATA: begin
                           if (type_data_ff && !limit_ok) begin
                              halt_in = hrl_pkg::HALT_LIMIT;
                           end else begin
                              if (type_data_ff) begin
                                 rsp_in.byte_valid   = 1'b1;
                                 rsp_in.data_byte    = byte_val;
                                 rsp_in.store_index  = 16'(stored_ff);
                                 rsp_in.load_address = addr_ff + {8'h00, field_ff};
                                 stored_in           = stored_ff + 1'b1;
                              end
                              field_in = field_next;
                              if (field_next == count_ff) phase_in = PH_CHECK;
                           end
                        end
                        default: begin
                           // checksum byte: record must sum to zero
                           if (sum_in != '0) halt_in = hrl_pkg::HALT_BAD_SUM;
                           else phase_in = PH_EOL;
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
         end
      end

      rsp_in.halted       = (halt_in != hrl_pkg::HALT_NONE);
      rsp_in.halt_reason  = halt_in;
      rsp_in.bytes_stored = 16'(stored_in);

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         high_ff      <= '0;
         odd_ff       <= 1'b0;
         count_ff     <= '0;
         field_ff     <= '0;
         sum_ff       <= '0;
         type_data_ff <= 1'b1;
         addr_ff      <= '0;
         stored_ff    <= '0;
         halt_ff      <= hrl_pkg::HALT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         odd_ff       <= odd_in;
         count_ff     <= count_in;
         field_ff     <= field_in;
         sum_ff       <= sum_in;
         type_data_ff <= type_data_in;
         addr_ff      <= addr_in;
         stored_ff    <= stored_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   // once halted, the reason never changes
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (halt_ff != hrl_pkg::HALT_NONE) |=> (halt_ff == $past(halt_ff)))
      else $error("halt reason changed after halt");

   // the count moves only with a stored byte
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (stored_ff != $past(stored_ff)) |->
         ($past(pop) && $past(rsp_in.byte_valid) && stored_ff == $past(stored_ff) + 1'b1))
      else $error("stored count moved without a stored byte");

   // digit pairing is aligned outside the hex fields
   a_digit_align: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_START || phase_ff == PH_EOL || phase_ff == PH_SKIP) |-> !odd_ff)
      else $error("odd digit pending outside hex fields");

   // a stalled result is not overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("result register overwritten while stalled");

endmodule
